// ===== sv/vtw_pkg.sv =====
// ----------------------------------------------------------------------------
// vtw_pkg
// Shared types and constants of the viewport tile walker: tile geometry,
// command codes, register indexes, the queue entry and the result layout.
// ----------------------------------------------------------------------------
`default_nettype none

package vtw_pkg;

	// tile and map geometry
	localparam int TILE_SHIFT  = 8;
	localparam int TILE_PIXELS = 1 << TILE_SHIFT;
	localparam int MAX_LEVEL   = 20;
	localparam int MAX_RESULTS = 64;
	localparam int CNT_W       = $clog2(MAX_RESULTS);
	localparam int POS_W       = 32;

	// field widths
	localparam int CMD_W    = 2;
	localparam int CENTER_W = 28;
	localparam int DELTA_W  = 29;
	localparam int LEFT_W   = 30;
	localparam int TOP_W    = 28;
	localparam int TILE_W   = MAX_LEVEL;
	localparam int OFF_W    = 12;
	localparam int KEY_W    = 2 * MAX_LEVEL;
	localparam int ZOOM_W   = 5;
	localparam int SCREEN_W = 11;
	localparam int CFG_W    = 11;
	localparam int IDX_W    = 2;

	// queue depths
	localparam int CMD_DEPTH = 2;
	localparam int RES_DEPTH = 4;

	// input command codes
	localparam logic [CMD_W-1:0] CMD_SET  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_MOVE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_WALK = 2'd2;

	// configuration register indexes
	typedef enum logic [IDX_W-1:0] {
		REG_ZOOM   = 2'd0,
		REG_WIDTH  = 2'd1,
		REG_HEIGHT = 2'd2
	} reg_idx_t;

	// operation carried from front to back
	typedef enum logic [1:0] {
		OP_SET,
		OP_MOVE,
		OP_WALK
	} op_t;

	typedef struct packed {
		op_t                     op;
		logic signed [POS_W-1:0] arg_x;
		logic signed [POS_W-1:0] arg_y;
	} cmd_t;

	// decoded configuration seen by the back end
	typedef struct packed {
		logic signed [POS_W-1:0] map_size;
		logic [TILE_W-1:0]       tile_mask;
		logic [SCREEN_W-1:0]     width;
		logic [SCREEN_W-1:0]     height;
	} cfg_t;

	typedef struct packed {
		logic signed [LEFT_W-1:0] view_left;
		logic [TOP_W-1:0]         view_top;
		logic [TILE_W-1:0]        tile_x;
		logic [TILE_W-1:0]        tile_y;
		logic signed [OFF_W-1:0]  offset_x;
		logic signed [OFF_W-1:0]  offset_y;
		logic [KEY_W-1:0]         tile_key;
		logic                     last;
	} result_t;

endpackage

`default_nettype wire

// ===== sv/vtw_fifo.sv =====
// ----------------------------------------------------------------------------
// vtw_fifo
// Small register queue with push/full and pop/empty; the oldest entry is
// shown on rdata while empty is low.
// ----------------------------------------------------------------------------
`default_nettype none

module vtw_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      rdata,
	output logic                  empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign rdata   = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

`default_nettype wire

// ===== sv/vtw_front.sv =====
// ----------------------------------------------------------------------------
// vtw_front
// Front end: holds the configuration registers, accepts input transactions
// and turns each command into a queue entry for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module vtw_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_valid,
	input  wire logic [vtw_pkg::IDX_W-1:0]     cfg_index,
	input  wire logic [vtw_pkg::CFG_W-1:0]     cfg_data,
	input  wire logic                          push,
	input  wire logic                          q_full,
	input  wire logic [vtw_pkg::CMD_W-1:0]     command,
	input  wire logic [vtw_pkg::CENTER_W-1:0]  center_x,
	input  wire logic [vtw_pkg::CENTER_W-1:0]  center_y,
	input  wire logic signed [vtw_pkg::DELTA_W-1:0] delta_x,
	input  wire logic signed [vtw_pkg::DELTA_W-1:0] delta_y,
	output logic                               q_push,
	output vtw_pkg::cmd_t                      q_data,
	output vtw_pkg::cfg_t                      cfg
);

	import vtw_pkg::*;

	logic [ZOOM_W-1:0]   zoom_q;
	logic [SCREEN_W-1:0] width_q;
	logic [SCREEN_W-1:0] height_q;
	logic [ZOOM_W-1:0]   level;
	logic                accept;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zoom_q   <= ZOOM_W'(1);
			width_q  <= '0;
			height_q <= '0;
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_ZOOM:   zoom_q   <= cfg_data[ZOOM_W-1:0];
				REG_WIDTH:  width_q  <= cfg_data[SCREEN_W-1:0];
				REG_HEIGHT: height_q <= cfg_data[SCREEN_W-1:0];
				default:    ;
			endcase
		end
	end

	// zoom clamped to the supported levels
	always_comb begin
		if (zoom_q < ZOOM_W'(1)) begin
			level = ZOOM_W'(1);
		end else if (zoom_q > ZOOM_W'(MAX_LEVEL)) begin
			level = ZOOM_W'(MAX_LEVEL);
		end else begin
			level = zoom_q;
		end
	end

	assign cfg.map_size  = POS_W'(TILE_PIXELS) << level;
	assign cfg.tile_mask = (TILE_W'(1) << level) - TILE_W'(1);
	assign cfg.width     = width_q;
	assign cfg.height    = height_q;

	// command decode; unknown codes are taken and dropped
	assign accept = push & ~q_full;

	always_comb begin
		q_data.op    = OP_WALK;
		q_data.arg_x = '0;
		q_data.arg_y = '0;
		q_push       = 1'b0;
		case (command)
			CMD_SET: begin
				q_data.op    = OP_SET;
				q_data.arg_x = $signed(POS_W'(center_x)) - $signed(POS_W'(width_q[SCREEN_W-1:1]));
				q_data.arg_y = $signed(POS_W'(center_y)) - $signed(POS_W'(height_q[SCREEN_W-1:1]));
				q_push       = accept;
			end
			CMD_MOVE: begin
				q_data.op    = OP_MOVE;
				q_data.arg_x = {{(POS_W - DELTA_W){delta_x[DELTA_W-1]}}, delta_x};
				q_data.arg_y = {{(POS_W - DELTA_W){delta_y[DELTA_W-1]}}, delta_y};
				q_push       = accept;
			end
			CMD_WALK: begin
				q_data.op = OP_WALK;
				q_push    = accept;
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

// ===== sv/vtw_back.sv =====
// ----------------------------------------------------------------------------
// vtw_back
// Back end: keeps the view rectangle, clamps and wraps it after each update
// and walks the visible tiles, one result per cycle unless the queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module vtw_back (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire vtw_pkg::cfg_t cfg,
	input  wire logic    q_empty,
	input  wire vtw_pkg::cmd_t q_data,
	output logic         q_pop,
	input  wire logic    r_full,
	output logic         r_push,
	output vtw_pkg::result_t r_data
);

	import vtw_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_VCLAMP,
		ST_VFIX,
		ST_HWRAP,
		ST_HSPAN,
		ST_VIEW,
		ST_WALK
	} state_t;

	state_t                  state_q;
	logic signed [POS_W-1:0] left_q;
	logic signed [POS_W-1:0] right_q;
	logic signed [POS_W-1:0] top_q;
	logic signed [POS_W-1:0] bottom_q;
	logic signed [POS_W-1:0] walk_x_q;
	logic signed [POS_W-1:0] walk_y_q;
	logic signed [POS_W-1:0] bound_q;
	logic [CNT_W-1:0]        count_q;

	logic signed [POS_W-1:0] m;
	logic signed [POS_W-1:0] w_s;
	logic signed [POS_W-1:0] h_s;
	logic signed [POS_W-1:0] excess;
	logic signed [POS_W-1:0] mag;
	logic signed [POS_W-1:0] rem;
	logic signed [POS_W-1:0] wrapped;
	logic signed [POS_W-1:0] walk_y_nxt;
	logic signed [POS_W-1:0] col;
	logic signed [POS_W-1:0] row;
	logic signed [POS_W-1:0] max_row;
	logic [TILE_W-1:0]       tx;
	logic [TILE_W-1:0]       ty;
	logic [KEY_W-1:0]        key;
	logic                    row_end;
	logic                    walk_done;

	assign m   = cfg.map_size;
	assign w_s = $signed(POS_W'(cfg.width));
	assign h_s = $signed(POS_W'(cfg.height));

	// vertical overshoot and horizontal reduction by whole map widths
	assign excess  = bottom_q - m;
	assign mag     = left_q[POS_W-1] ? -left_q : left_q;
	assign rem     = mag & (m - POS_W'(1));
	assign wrapped = left_q[POS_W-1] ? -rem : rem;

	// tile under the walk position
	assign col     = walk_x_q >>> TILE_SHIFT;
	assign row     = walk_y_q >>> TILE_SHIFT;
	assign max_row = $signed(POS_W'(cfg.tile_mask));
	assign tx      = col[TILE_W-1:0] & cfg.tile_mask;

	always_comb begin
		if (row < 0) begin
			ty = '0;
		end else if (row > max_row) begin
			ty = cfg.tile_mask;
		end else begin
			ty = row[TILE_W-1:0];
		end
	end

	// quadkey: row bit above column bit at every level
	always_comb begin
		for (int i = 0; i < TILE_W; i++) begin
			key[2*i]     = tx[i];
			key[2*i + 1] = ty[i];
		end
	end

	// end of row and end of walk
	assign walk_y_nxt = walk_y_q + POS_W'(TILE_PIXELS);
	assign row_end    = (walk_x_q >= bound_q);
	assign walk_done  = (count_q == CNT_W'(MAX_RESULTS - 1)) ||
		(row_end && ((walk_y_q >= bottom_q) ||
		((walk_y_nxt >= bottom_q) && (walk_y_q[TILE_SHIFT-1:0] == '0))));

	// handshakes toward both queues
	assign q_pop  = (state_q == ST_IDLE) && !q_empty;
	assign r_push = ((state_q == ST_VIEW) || (state_q == ST_WALK)) && !r_full;

	// result payload
	always_comb begin
		r_data           = '0;
		r_data.view_left = left_q[LEFT_W-1:0];
		r_data.view_top  = top_q[TOP_W-1:0];
		if (state_q == ST_WALK) begin
			r_data.tile_x   = tx;
			r_data.tile_y   = ty;
			r_data.offset_x = (walk_x_q[OFF_W-1:0] & ~OFF_W'(TILE_PIXELS - 1)) -
				left_q[OFF_W-1:0];
			r_data.offset_y = (walk_y_q[OFF_W-1:0] & ~OFF_W'(TILE_PIXELS - 1)) -
				top_q[OFF_W-1:0];
			r_data.tile_key = key;
			r_data.last     = walk_done;
		end else begin
			r_data.last = 1'b1;
		end
	end

	// sequencer and view state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			left_q   <= '0;
			right_q  <= '0;
			top_q    <= '0;
			bottom_q <= '0;
			walk_x_q <= '0;
			walk_y_q <= '0;
			bound_q  <= '0;
			count_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						case (q_data.op)
							OP_SET: begin
								left_q   <= q_data.arg_x;
								right_q  <= q_data.arg_x + w_s;
								top_q    <= q_data.arg_y;
								bottom_q <= q_data.arg_y + h_s;
								state_q  <= ST_VCLAMP;
							end
							OP_MOVE: begin
								left_q   <= left_q + q_data.arg_x;
								right_q  <= right_q + q_data.arg_x;
								top_q    <= top_q + q_data.arg_y;
								bottom_q <= bottom_q + q_data.arg_y;
								state_q  <= ST_VCLAMP;
							end
							OP_WALK: begin
								bound_q  <= (left_q > right_q) ? right_q + m : right_q;
								walk_x_q <= left_q;
								walk_y_q <= top_q;
								count_q  <= '0;
								state_q  <= ST_WALK;
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_VCLAMP: begin
					if (m < h_s) begin
						top_q    <= '0;
						bottom_q <= m;
					end else if (top_q < 0) begin
						bottom_q <= bottom_q - top_q;
						top_q    <= '0;
					end else if (bottom_q >= m) begin
						top_q    <= top_q - excess;
						bottom_q <= m;
					end
					state_q <= ST_VFIX;
				end
				ST_VFIX: begin
					if (top_q < 0) begin
						top_q    <= '0;
						bottom_q <= m;
					end
					state_q <= ST_HWRAP;
				end
				ST_HWRAP: begin
					if ((left_q > m) || (left_q < -m)) begin
						left_q  <= wrapped;
						right_q <= right_q - left_q;
						state_q <= ST_HSPAN;
					end else begin
						state_q <= ST_VIEW;
					end
				end
				ST_HSPAN: begin
					right_q <= right_q + left_q;
					state_q <= ST_VIEW;
				end
				ST_VIEW: begin
					if (!r_full) begin
						state_q <= ST_IDLE;
					end
				end
				ST_WALK: begin
					if (!r_full) begin
						count_q <= count_q + 1'b1;
						if (walk_done) begin
							state_q <= ST_IDLE;
						end else if (row_end) begin
							walk_x_q <= left_q;
							walk_y_q <= walk_y_nxt;
						end else begin
							walk_x_q <= walk_x_q + POS_W'(TILE_PIXELS);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== sv/viewport_tile_walker.sv =====
// ----------------------------------------------------------------------------
// viewport_tile_walker
// Keeps a map viewport and lists the tiles it covers, with quadkeys.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter through a queue port (push/full). Set centre and move each
//   give one result with the new view corner and last set; list tiles gives
//   one result per visible tile, row by row, last set on the final tile and
//   at most 64 tiles. Command code 3 is taken and gives no result.
//   Results leave through a queue port (empty/pop); the oldest result is on
//   the ports while empty is low.
//   Configuration (zoom, screen size) is written on the cfg port, which is
//   always ready; write it only while no command is in flight.
//   Flow: a command waits in a two-entry queue for the back-end sequencer,
//   which works on one command at a time. A view update passes there through
//   take, clamp, fix-up, wrap check and write out, with a span step after the
//   wrap check when the left edge is reduced by map widths. A tile listing
//   sets up the walk and then writes the tiles in turn. A result shows on the
//   ports in the cycle after it is written to the four-entry result queue.
//   When the receiver stops popping, the result queue fills, the sequencer
//   holds, the command queue fills and full rises.
//   Reset empties both queues, sets zoom to 1, screen size to 0 and the view
//   to the origin.
// ----------------------------------------------------------------------------
`default_nettype none

module viewport_tile_walker #(
	parameter int CMD_DEPTH = vtw_pkg::CMD_DEPTH,
	parameter int RES_DEPTH = vtw_pkg::RES_DEPTH
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [vtw_pkg::IDX_W-1:0]          cfg_index,
	input  wire logic [vtw_pkg::CFG_W-1:0]          cfg_data,
	input  wire logic                               push,
	output logic                                    full,
	input  wire logic [vtw_pkg::CMD_W-1:0]          command,
	input  wire logic [vtw_pkg::CENTER_W-1:0]       center_x,
	input  wire logic [vtw_pkg::CENTER_W-1:0]       center_y,
	input  wire logic signed [vtw_pkg::DELTA_W-1:0] delta_x,
	input  wire logic signed [vtw_pkg::DELTA_W-1:0] delta_y,
	output logic                                    empty,
	input  wire logic                               pop,
	output logic signed [vtw_pkg::LEFT_W-1:0]       view_left,
	output logic [vtw_pkg::TOP_W-1:0]               view_top,
	output logic [vtw_pkg::TILE_W-1:0]              tile_x,
	output logic [vtw_pkg::TILE_W-1:0]              tile_y,
	output logic signed [vtw_pkg::OFF_W-1:0]        offset_x,
	output logic signed [vtw_pkg::OFF_W-1:0]        offset_y,
	output logic [vtw_pkg::KEY_W-1:0]               tile_key,
	output logic                                    last
);

	import vtw_pkg::*;

	cfg_t    cfg;
	cmd_t    cmd_in;
	cmd_t    cmd_out;
	result_t res_in;
	result_t res_out;
	logic    cmd_push;
	logic    cmd_full;
	logic    cmd_pop;
	logic    cmd_empty;
	logic    res_push;
	logic    res_full;

	assign cfg_ready = 1'b1;
	assign full      = cmd_full;

	// command decode and configuration
	vtw_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.q_full    (cmd_full),
		.command   (command),
		.center_x  (center_x),
		.center_y  (center_y),
		.delta_x   (delta_x),
		.delta_y   (delta_y),
		.q_push    (cmd_push),
		.q_data    (cmd_in),
		.cfg       (cfg)
	);

	// queue between front and back
	vtw_fifo #(
		.WIDTH ($bits(cmd_t)),
		.DEPTH (CMD_DEPTH)
	) u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (cmd_in),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.rdata  (cmd_out),
		.empty  (cmd_empty)
	);

	// view update and tile walk
	vtw_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.q_empty (cmd_empty),
		.q_data  (cmd_out),
		.q_pop   (cmd_pop),
		.r_full  (res_full),
		.r_push  (res_push),
		.r_data  (res_in)
	);

	// result queue
	vtw_fifo #(
		.WIDTH ($bits(result_t)),
		.DEPTH (RES_DEPTH)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_in),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_out),
		.empty  (empty)
	);

	assign view_left = res_out.view_left;
	assign view_top  = res_out.view_top;
	assign tile_x    = res_out.tile_x;
	assign tile_y    = res_out.tile_y;
	assign offset_x  = res_out.offset_x;
	assign offset_y  = res_out.offset_y;
	assign tile_key  = res_out.tile_key;
	assign last      = res_out.last;

endmodule

`default_nettype wire

// ===== sv/vtw_checker.sv =====
// ----------------------------------------------------------------------------
// vtw_checker
// Port-level checks of the viewport tile walker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module vtw_checker (
	input wire logic                               clk,
	input wire logic                               arst_n,
	input wire logic                               empty,
	input wire logic                               pop,
	input wire logic signed [vtw_pkg::LEFT_W-1:0]  view_left,
	input wire logic [vtw_pkg::TOP_W-1:0]          view_top,
	input wire logic signed [vtw_pkg::OFF_W-1:0]   offset_x,
	input wire logic signed [vtw_pkg::OFF_W-1:0]   offset_y,
	input wire logic [vtw_pkg::KEY_W-1:0]          tile_key,
	input wire logic                               last
);

	import vtw_pkg::*;

	// a waiting result is not withdrawn, and its key and last flag do not change
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(tile_key) && $stable(last)))
		else $error("waiting result changed before its transaction");

	// a tile origin sits on the tile grid in x
	a_grid_x: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !last) |->
		((offset_x[TILE_SHIFT-1:0] + view_left[TILE_SHIFT-1:0]) == '0))
		else $error("tile x offset off the tile grid");

	// a tile origin sits on the tile grid in y
	a_grid_y: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !last) |->
		((offset_y[TILE_SHIFT-1:0] + view_top[TILE_SHIFT-1:0]) == '0))
		else $error("tile y offset off the tile grid");

	// the view corner stays put within one tile listing
	a_walk_view: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && !last) |=>
		(empty || (view_left == $past(view_left) && view_top == $past(view_top))))
		else $error("view corner changed inside a tile listing");

endmodule

bind viewport_tile_walker vtw_checker u_vtw_checker (.*);

`default_nettype wire
